[design/signed_int_to_decimal_ascii_macros.svh]
// Assertion macros shared by the decimal text converter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIDTA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sidta: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SIDTA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sidta: next-cycle check failed");

`endif

[design/sidta_pkg.sv]
// Shared types and constants of the signed integer to decimal ASCII converter.
// No dependencies; used by sidta_bcd_conv, sidta_emit and the top level.
`default_nettype none

package sidta_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_W     = 6;
    localparam int TDATA_IN_W = 32;
    localparam int TDATA_OUT_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // Finished conversion handed from the BCD converter to the emitter
    typedef struct packed {
        logic             done;
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } bcd_result_t;

endpackage

`default_nettype wire

[design/signed_int_to_decimal_ascii.sv]
// Signed 32-bit integer to decimal ASCII text, one character per output transaction.
// The first character follows a 32-step bit-serial BCD conversion and one skip step per
// leading zero dropped; then one character per cycle while m_tready is high.
// One item at a time: a new value is taken once the last character is in the output register.
// Reset (aresetn low, synchronous) clears the sequencers and the output valid.
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [sidta_pkg::TDATA_IN_W-1:0]   s_tdata,   // [31:0] value
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [sidta_pkg::TDATA_OUT_W-1:0]       m_tdata,   // [5:0] char_code, [7:6] zero
    output logic                                    m_tlast    // is_last
);

    logic                   conv_idle;
    logic                   emit_idle;
    logic                   start;
    sidta_pkg::bcd_result_t bcd_res;

    // Take a new value only when both stages are free
    assign s_tready = conv_idle && emit_idle;
    assign start    = s_tvalid && s_tready;

    sidta_bcd_conv u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .value   (s_tdata[sidta_pkg::VALUE_W-1:0]),
        .idle    (conv_idle),
        .result  (bcd_res)
    );

    sidta_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .bcd_in   (bcd_res),
        .idle     (emit_idle),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[design/sidta_bcd_conv.sv]
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit per cycle.
// Depends on sidta_pkg.
`default_nettype none

module sidta_bcd_conv (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [sidta_pkg::VALUE_W-1:0]     value,
    output logic                                   idle,
    output sidta_pkg::bcd_result_t                 result
);

    localparam int BIT_CNT_W = $clog2(sidta_pkg::VALUE_W);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [BIT_CNT_W-1:0]            bit_cnt_reg, bit_cnt_next;
    logic [sidta_pkg::VALUE_W-1:0]   mag_reg, mag_next;
    logic [sidta_pkg::BCD_W-1:0]     bcd_reg, bcd_next;
    logic                            neg_reg, neg_next;
    logic [sidta_pkg::BCD_W-1:0]     bcd_adj;

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        logic [3:0] dig;
        dig = 4'd0;
        for (int i = 0; i < sidta_pkg::NUM_DIGITS; i++) begin
            dig = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (dig >= 4'd5) ? (dig + 4'd3) : dig;
        end
    end

    // Load on start, then shift the magnitude MSB first into the BCD register
    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        bit_cnt_next = bit_cnt_reg;
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        neg_next     = neg_reg;
        if (start) begin
            busy_next    = 1'b1;
            bit_cnt_next = BIT_CNT_W'(sidta_pkg::VALUE_W - 1);
            neg_next     = value[sidta_pkg::VALUE_W-1];
            mag_next     = value[sidta_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
            bcd_next     = '0;
        end else if (busy_reg) begin
            bcd_next     = {bcd_adj[sidta_pkg::BCD_W-2:0], mag_reg[sidta_pkg::VALUE_W-1]};
            mag_next     = {mag_reg[sidta_pkg::VALUE_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - 1'b1;
            if (bit_cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end else begin
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    // Data path
    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

    assign idle        = !busy_reg && !done_reg;
    assign result.done = done_reg;
    assign result.neg  = neg_reg;
    assign result.bcd  = bcd_reg;

endmodule

`default_nettype wire

[design/sidta_emit.sv]
// Character sequencer: skips leading zero digits, emits sign and digits one per transaction.
// Depends on sidta_pkg and signed_int_to_decimal_ascii_macros.svh.
`default_nettype none
`include "signed_int_to_decimal_ascii_macros.svh"

module sidta_emit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire sidta_pkg::bcd_result_t             bcd_in,
    output logic                                    idle,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [sidta_pkg::TDATA_OUT_W-1:0]       m_tdata,   // [5:0] char_code, rest zero
    output logic                                    m_tlast    // is_last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SKIP  = 2'd1;
    localparam logic [1:0] ST_SIGN  = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    localparam int BCD_W = sidta_pkg::BCD_W;
    localparam int CNT_W = sidta_pkg::CNT_W;

    logic [1:0]                     state_reg, state_next;
    logic [BCD_W-1:0]               bcd_reg, bcd_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           neg_reg, neg_next;
    logic                           valid_reg, valid_next;
    logic [sidta_pkg::CHAR_W-1:0]   char_reg, char_next;
    logic                           last_reg, last_next;
    logic [3:0]                     top_dig;
    logic                           slot_free;

    assign top_dig   = bcd_reg[BCD_W-1 -: 4];
    assign slot_free = !valid_reg || m_tready;

    // Sequencer and output register
    always_comb begin
        state_next = state_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        valid_next = valid_reg && !m_tready;
        char_next  = char_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (bcd_in.done) begin
                    bcd_next   = bcd_in.bcd;
                    neg_next   = bcd_in.neg;
                    cnt_next   = CNT_W'(sidta_pkg::NUM_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // drop leading zeros, keep at least one digit
                if (top_dig == 4'd0 && cnt_reg > CNT_W'(1)) begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (slot_free) begin
                    valid_next = 1'b1;
                    char_next  = sidta_pkg::CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (slot_free) begin
                    valid_next = 1'b1;
                    char_next  = sidta_pkg::CHAR_ZERO + {2'b00, top_dig};
                    last_next  = (cnt_reg == CNT_W'(1));
                    bcd_next   = {bcd_reg[BCD_W-5:0], 4'd0};
                    cnt_next   = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Data path
    always_ff @(posedge aclk) begin
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign idle     = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, char_reg};
    assign m_tlast  = last_reg;

    // Checks
    `SIDTA_ASSERT_IMP(a_done_when_idle, aclk, aresetn, bcd_in.done, state_reg == ST_IDLE)
    `SIDTA_ASSERT_IMP(a_digit_cnt_live, aclk, aresetn, state_reg == ST_DIGIT, cnt_reg != '0)
    `SIDTA_ASSERT_IMP(a_minus_not_last, aclk, aresetn,
        valid_reg && char_reg == sidta_pkg::CHAR_MINUS, !last_reg)
    `SIDTA_ASSERT_NXT(a_last_ends_item, aclk, aresetn,
        state_reg == ST_DIGIT && slot_free && cnt_reg == CNT_W'(1),
        state_reg == ST_IDLE && valid_reg && last_reg)

endmodule

`default_nettype wire
